### sv/rpfc_pkg.sv
// Shared types and constants for the RGBA pixel format converter.
package rpfc_pkg;

  // Output format codes, as held in the output_format register.
  localparam logic [1:0] FMT_MONO   = 2'd0;
  localparam logic [1:0] FMT_RGB332 = 2'd1;
  localparam logic [1:0] FMT_RGB565 = 2'd2;
  localparam logic [1:0] FMT_BGRA   = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic       REG_OUTPUT_FORMAT   = 1'b0;
  localparam logic       REG_ALPHA_CUTOFF    = 1'b1;
  localparam logic [1:0] FORMAT_RESET        = FMT_RGB565;
  localparam logic [8:0] THRESHOLD_RESET     = 9'd128;

  // Fixed codes for transparent pixels.
  localparam logic [7:0]  RGB332_CLEAR = 8'hC0;
  localparam logic [15:0] RGB565_CLEAR = 16'hE000;

  // Live configuration as seen by the front end.
  typedef struct packed {
    logic [1:0] output_format;
    logic [8:0] alpha_cutoff;
  } cfg_t;

  // One classified pixel waiting for conversion.
  typedef struct packed {
    logic [1:0] output_format;
    logic       clear;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] mono_byte;
    logic       row_end;
  } queue_entry_t;

endpackage

### sv/rpfc_if.sv
// Stream interfaces for pixels in and converted words out.
interface pixel_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       row_end;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output row_end, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input row_end, output ready);
endinterface

interface pixel_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_data;
  logic        row_done;

  modport source (output valid, output pixel_data, output row_done, input ready);
  modport sink   (input valid, input pixel_data, input row_done, output ready);
endinterface

### sv/rpfc_front.sv
// Front end: accepts pixels, packs mono bits and queues one entry per result.
module rpfc_front
  import rpfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  pixel_in_if.sink      pix_in,
  input  logic          q_full,
  output logic          push,
  output queue_entry_t  push_entry
);

  logic [7:0] mono_acc;
  logic [2:0] mono_pos;
  logic [7:0] mono_acc_next;
  logic [2:0] mono_pos_next;
  logic       accept;
  logic       is_black;
  logic       is_mono;
  logic       mono_emit;

  // A word is taken whenever the queue has room.
  assign pix_in.ready = !q_full;
  assign accept       = pix_in.valid && !q_full;

  // Mono bit packing, MSB first.
  assign is_mono       = (cfg.output_format == FMT_MONO);
  assign is_black      = (pix_in.red == 8'd0) && (pix_in.green == 8'd0) &&
                         (pix_in.blue == 8'd0);
  assign mono_acc_next = is_black ? (mono_acc | (8'h80 >> mono_pos)) : mono_acc;
  assign mono_pos_next = mono_pos + 3'd1;
  assign mono_emit     = (mono_pos_next == 3'd0) || pix_in.row_end;

  // A mono pixel that neither fills a byte nor ends a row makes no entry.
  assign push = accept && (!is_mono || mono_emit);

  always_comb begin
    push_entry.output_format = cfg.output_format;
    push_entry.clear         = ({1'b0, pix_in.alpha} < cfg.alpha_cutoff);
    push_entry.red           = pix_in.red;
    push_entry.green         = pix_in.green;
    push_entry.blue          = pix_in.blue;
    push_entry.alpha         = pix_in.alpha;
    push_entry.mono_byte     = mono_acc_next;
    push_entry.row_end       = pix_in.row_end;
  end

  // Mono state moves only on mono pixels and is kept across other formats.
  always_ff @(posedge clk) begin
    if (rst) begin
      mono_acc <= 8'd0;
      mono_pos <= 3'd0;
    end else if (accept && is_mono) begin
      if (mono_emit) begin
        mono_acc <= 8'd0;
        mono_pos <= 3'd0;
      end else begin
        mono_acc <= mono_acc_next;
        mono_pos <= mono_pos_next;
      end
    end
  end

endmodule

### sv/rpfc_queue.sv
// Two-entry queue between the front end and the conversion back end.
module rpfc_queue
  import rpfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  queue_entry_t  push_entry,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output queue_entry_t  head
);

  queue_entry_t slot0;
  queue_entry_t slot1;
  logic         valid0;
  logic         valid1;
  logic         do_pop;

  assign full       = valid1;
  assign head_valid = valid0;
  assign head       = slot0;
  assign do_pop     = pop && valid0;

  // Occupancy flags; slot0 is always the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else begin
      case ({push, do_pop})
        2'b10: begin
          if (valid0) begin
            valid1 <= 1'b1;
          end else begin
            valid0 <= 1'b1;
          end
        end
        2'b01: begin
          valid0 <= valid1;
          valid1 <= 1'b0;
        end
        default: begin
          valid0 <= valid0;
          valid1 <= valid1;
        end
      endcase
    end
  end

  // Entry storage shifts toward the head on a pop.
  always_ff @(posedge clk) begin
    case ({push, do_pop})
      2'b11: begin
        if (valid1) begin
          slot0 <= slot1;
          slot1 <= push_entry;
        end else begin
          slot0 <= push_entry;
        end
      end
      2'b10: begin
        if (valid0) begin
          slot1 <= push_entry;
        end else begin
          slot0 <= push_entry;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

endmodule

### sv/rpfc_back.sv
// Back end: converts queued pixels to the output word and holds the result.
module rpfc_back
  import rpfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  queue_entry_t  head,
  output logic          pop,
  pixel_out_if.source   pix_out
);

  logic        out_valid;
  logic [31:0] out_data;
  logic        out_row_done;
  logic [31:0] word;

  // Format conversion of the head entry.
  always_comb begin
    case (head.output_format)
      FMT_MONO: begin
        word = {24'd0, head.mono_byte};
      end
      FMT_RGB332: begin
        if (head.clear) begin
          word = {24'd0, RGB332_CLEAR};
        end else begin
          word = {24'd0, head.red[7:5], head.green[7:5], head.blue[7:6]};
        end
      end
      FMT_RGB565: begin
        if (head.clear) begin
          word = {16'd0, RGB565_CLEAR};
        end else begin
          word = {16'd0, head.red[7:3], head.green[7:2], head.blue[7:3]};
        end
      end
      default: begin
        word = {head.alpha, head.red, head.green, head.blue};
      end
    endcase
  end

  // The output register loads when empty or when its word is taken.
  assign pop = head_valid && (!out_valid || pix_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || pix_out.ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data     <= word;
      out_row_done <= head.row_end;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.pixel_data = out_data;
  assign pix_out.row_done   = out_row_done;

endmodule

### sv/rgba_pixel_format_converter_top.sv
// Top level of the RGBA pixel format converter.
//
//   Channel   Direction  Payload                              Handshake
//   pix_in    in         red, green, blue, alpha, row_end     valid/ready
//   pix_out   out        pixel_data[31:0], row_done           valid/ready
//   APB       in         output_format @0x0, threshold @0x4   psel/penable/pready
//
// One pixel is accepted per cycle while the queue has room; each result is
// registered in the queue and then in the output register on its way out.
// Mono pixels that neither complete a byte nor end a row produce no result.
// The two-entry queue absorbs output stalls; input ready drops once it is full.
// Reset is synchronous and clears the queue, output valid, mono state and
// loads the register defaults (rgb565, threshold 128).
module rgba_pixel_format_converter_top
  import rpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pixel_in_if.sink    pix_in,
  pixel_out_if.source pix_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t         cfg;
  logic         push;
  queue_entry_t push_entry;
  logic         pop;
  logic         q_full;
  logic         head_valid;
  queue_entry_t head;
  logic         reg_sel;
  logic         cfg_write;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_format <= FORMAT_RESET;
      cfg.alpha_cutoff  <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_OUTPUT_FORMAT: cfg.output_format <= pwdata[1:0];
        REG_ALPHA_CUTOFF:  cfg.alpha_cutoff  <= pwdata[8:0];
        default:           cfg.output_format <= cfg.output_format;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OUTPUT_FORMAT: prdata = {30'd0, cfg.output_format};
      REG_ALPHA_CUTOFF:  prdata = {23'd0, cfg.alpha_cutoff};
      default:           prdata = 32'd0;
    endcase
  end

  rpfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix_in     (pix_in),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  rpfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  rpfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .pix_out    (pix_out)
  );

endmodule
